// ===== sv/etrb_pkg.sv =====
// ----------------------------------------------------------------------------
// etrb_pkg
// Shared types and constants for the event trace ring buffer: request and
// result layouts, queued command format, stored entry layout, op codes.
// ----------------------------------------------------------------------------
package etrb_pkg;

  // ring depth and derived index widths
  localparam int DEPTH  = 64;
  localparam int SLOT_W = $clog2(DEPTH);
  localparam int WIDX_W = $clog2(DEPTH + 1);

  // op codes carried in a request
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_EVENT = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // saturation limit of the repeat counter
  localparam logic [15:0] DUP_MAX = 16'hFFFF;

  // request fields as seen on the ports
  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] event_id;
    logic [7:0]  data_a;
    logic [7:0]  data_b;
    logic [7:0]  data_c;
    logic [5:0]  read_slot;
  } etrb_request_t;

  // result fields as seen on the ports
  typedef struct packed {
    logic [5:0]  slot;
    logic        was_duplicate;
    logic [31:0] entry_time;
    logic [31:0] entry_delta;
    logic [15:0] entry_event_id;
    logic [7:0]  entry_data_a;
    logic [7:0]  entry_data_b;
    logic [7:0]  entry_data_c;
    logic [15:0] entry_dup_count;
    logic [31:0] entry_dup_time;
    logic [15:0] wrap_count;
    logic [31:0] now_tick;
  } etrb_result_t;

  // command class decided by the front end
  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_EVENT,
    KIND_READ,
    KIND_IDLE
  } etrb_kind_t;

  // one queued command
  typedef struct packed {
    etrb_kind_t  kind;
    logic [15:0] event_id;
    logic [7:0]  data_a;
    logic [7:0]  data_b;
    logic [7:0]  data_c;
    logic [5:0]  read_slot;
  } etrb_item_t;

  // queue head presented to the back end
  typedef struct packed {
    logic       valid;
    etrb_item_t item;
  } etrb_queue_t;

  // one stored trace entry
  typedef struct packed {
    logic [31:0] time_stamp;
    logic [31:0] delta;
    logic [15:0] event_id;
    logic [7:0]  data_a;
    logic [7:0]  data_b;
    logic [7:0]  data_c;
    logic [15:0] dup_count;
    logic [31:0] dup_time;
  } etrb_entry_t;

  // back end sequencer states
  typedef enum logic {
    ST_RUN,
    ST_READ
  } etrb_state_t;

endpackage

// ===== sv/etrb_front.sv =====
// ----------------------------------------------------------------------------
// etrb_front
// Accepts requests, classifies the op and holds them in a two-entry queue
// until the back end takes them.
// ----------------------------------------------------------------------------
module etrb_front import etrb_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  etrb_request_t request,
  output logic          busy,
  output etrb_queue_t   head,
  input  logic          pop
);

  etrb_item_t  entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  etrb_item_t  item_in;

  // request is taken while the queue has room
  assign busy = (count == 2'd2);
  assign push = start && !busy;

  // classify the op
  always_comb begin
    item_in.event_id  = request.event_id;
    item_in.data_a    = request.data_a;
    item_in.data_b    = request.data_b;
    item_in.data_c    = request.data_c;
    item_in.read_slot = request.read_slot;
    case (request.op)
      OP_TICK:  item_in.kind = KIND_TICK;
      OP_EVENT: item_in.kind = KIND_EVENT;
      OP_READ:  item_in.kind = KIND_READ;
      default:  item_in.kind = KIND_IDLE;
    endcase
  end

  // queue head
  assign head.valid = (count != 2'd0);
  assign head.item  = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= item_in;
    end
  end

endmodule

// ===== sv/etrb_back.sv =====
// ----------------------------------------------------------------------------
// etrb_back
// Carries out queued commands: tick counting, event logging with repeat
// merging into the last entry, and entry reads from the trace store.
// ----------------------------------------------------------------------------
module etrb_back import etrb_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  etrb_queue_t  head,
  output logic         pop,
  output logic         done,
  output etrb_result_t result
);

  etrb_entry_t  mem [DEPTH];
  logic [DEPTH-1:0] valid;

  etrb_state_t  state, state_next;
  logic         done_next;
  etrb_result_t result_next;

  logic [31:0]       tick, tick_next;
  logic [WIDX_W-1:0] widx, widx_next;
  logic [SLOT_W-1:0] last_slot, last_slot_next;
  logic              have_prev, have_prev_next;
  logic [15:0]       wraps, wraps_next;
  etrb_entry_t       shadow, shadow_next;

  logic              mem_we;
  logic [SLOT_W-1:0] waddr;
  etrb_entry_t       wdata;
  logic [SLOT_W-1:0] raddr;
  etrb_entry_t       rd_data;
  logic              rd_valid;
  logic [5:0]        rd_slot;
  logic              rd_inrange;
  logic              rd_issue;

  logic              wrapped;
  logic [SLOT_W-1:0] wslot;
  logic              is_dup;
  etrb_entry_t       upd;

  // state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      done      <= 1'b0;
      tick      <= '0;
      widx      <= '0;
      last_slot <= '0;
      have_prev <= 1'b0;
      wraps     <= '0;
      valid     <= '0;
    end else begin
      state     <= state_next;
      done      <= done_next;
      tick      <= tick_next;
      widx      <= widx_next;
      last_slot <= last_slot_next;
      have_prev <= have_prev_next;
      wraps     <= wraps_next;
      if (mem_we) begin
        valid[waddr] <= 1'b1;
      end
    end
  end

  // result and shadow of the last written entry
  always_ff @(posedge clk) begin
    result <= result_next;
    shadow <= shadow_next;
    if (rd_issue) begin
      rd_slot    <= head.item.read_slot;
      rd_inrange <= (int'(head.item.read_slot) < DEPTH);
    end
  end

  // trace store, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_data  <= mem[raddr];
    rd_valid <= valid[raddr];
  end

  // event decode against the last entry
  always_comb begin
    wrapped = (widx == WIDX_W'(DEPTH));
    wslot   = wrapped ? '0 : SLOT_W'(widx);
    is_dup  = have_prev && (shadow.event_id == head.item.event_id);
  end

  // sequencer
  always_comb begin
    state_next     = state;
    done_next      = 1'b0;
    result_next    = '0;
    tick_next      = tick;
    widx_next      = widx;
    last_slot_next = last_slot;
    have_prev_next = have_prev;
    wraps_next     = wraps;
    shadow_next    = shadow;
    pop            = 1'b0;
    mem_we         = 1'b0;
    waddr          = last_slot;
    wdata          = shadow;
    raddr          = SLOT_W'(head.item.read_slot);
    rd_issue       = 1'b0;
    upd            = shadow;
    case (state)
      ST_RUN: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.item.kind)
            KIND_TICK: begin
              tick_next              = tick + 32'd1;
              done_next              = 1'b1;
              result_next.wrap_count = wraps;
              result_next.now_tick   = tick + 32'd1;
            end
            KIND_EVENT: begin
              if (wrapped) begin
                wraps_next = wraps + 16'd1;
                widx_next  = '0;
              end
              if (is_dup) begin
                // merge into the last written entry
                if (shadow.dup_count != DUP_MAX) begin
                  upd.dup_count = shadow.dup_count + 16'd1;
                end
                upd.dup_time  = tick;
                waddr         = last_slot;
                result_next.slot          = 6'(last_slot);
                result_next.was_duplicate = 1'b1;
              end else begin
                // fresh entry at the write index
                upd.time_stamp = tick;
                upd.delta      = (wslot == '0) ? 32'd0 : (tick - shadow.time_stamp);
                upd.event_id   = head.item.event_id;
                upd.data_a     = head.item.data_a;
                upd.data_b     = head.item.data_b;
                upd.data_c     = head.item.data_c;
                upd.dup_count  = '0;
                upd.dup_time   = '0;
                waddr          = wslot;
                last_slot_next = wslot;
                have_prev_next = 1'b1;
                widx_next      = WIDX_W'(wslot) + WIDX_W'(1);
                result_next.slot = 6'(wslot);
              end
              mem_we      = 1'b1;
              wdata       = upd;
              shadow_next = upd;
              done_next   = 1'b1;
              result_next.entry_time      = upd.time_stamp;
              result_next.entry_delta     = upd.delta;
              result_next.entry_event_id  = upd.event_id;
              result_next.entry_data_a    = upd.data_a;
              result_next.entry_data_b    = upd.data_b;
              result_next.entry_data_c    = upd.data_c;
              result_next.entry_dup_count = upd.dup_count;
              result_next.entry_dup_time  = upd.dup_time;
              result_next.wrap_count      = wrapped ? (wraps + 16'd1) : wraps;
              result_next.now_tick        = tick;
            end
            KIND_READ: begin
              rd_issue   = 1'b1;
              state_next = ST_READ;
            end
            default: begin
              done_next              = 1'b1;
              result_next.wrap_count = wraps;
              result_next.now_tick   = tick;
            end
          endcase
        end
      end
      ST_READ: begin
        // store data arrives in the cycle after the address
        done_next              = 1'b1;
        state_next             = ST_RUN;
        result_next.slot       = rd_slot;
        result_next.wrap_count = wraps;
        result_next.now_tick   = tick;
        if (rd_inrange && rd_valid) begin
          result_next.entry_time      = rd_data.time_stamp;
          result_next.entry_delta     = rd_data.delta;
          result_next.entry_event_id  = rd_data.event_id;
          result_next.entry_data_a    = rd_data.data_a;
          result_next.entry_data_b    = rd_data.data_b;
          result_next.entry_data_c    = rd_data.data_c;
          result_next.entry_dup_count = rd_data.dup_count;
          result_next.entry_dup_time  = rd_data.dup_time;
        end
      end
      default: begin
        state_next = ST_RUN;
      end
    endcase
  end

endmodule

// ===== sv/event_trace_ring_buffer.sv =====
// ----------------------------------------------------------------------------
// event_trace_ring_buffer
// Trace ring buffer with duplicate compression: ticks advance a time base,
// events are logged or merged into the last entry, reads return any entry.
//
//   channel   ports                  handshake
//   -------   --------------------   -----------------------------------
//   request   start, busy, request   taken when start is high, busy low
//   result    done, result           valid for the single cycle done is high
//
// Tick and event requests can follow back to back in the back end; a read
// passes through ST_RUN and ST_READ, set by the registered store read.
// Results are registered; a read also passes the registered store read.
// busy rises only when the two-entry request queue is full.
// Reset clears counters, queue and the per-entry valid bits; no sweep needed.
// The receiver cannot stall results.
// ----------------------------------------------------------------------------
module event_trace_ring_buffer import etrb_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  etrb_request_t request,
  output logic          busy,
  output logic          done,
  output etrb_result_t  result
);

  etrb_queue_t head;
  logic        pop;

  // accept and classify
  etrb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .request (request),
    .busy    (busy),
    .head    (head),
    .pop     (pop)
  );

  // execute against the trace store
  etrb_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .done   (done),
    .result (result)
  );

endmodule
